[rtl/core/ic3_pkg.sv]
package ic3_pkg;

  // Fixed field widths
  localparam int PIXEL_W    = 16;
  localparam int OUT_W      = 28;
  localparam int KROW_W     = 24;
  localparam int COEF_W     = 8;
  localparam int DIM_CFG_W  = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = KROW_W;

  // Geometry
  localparam int TAPS       = 9;
  localparam int KDIM       = 3;
  localparam int MIN_DIM    = 3;
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = 12;

  // Defaults for top-level parameters
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int PIXEL_BITS_DEF = 16;

  // Register reset values
  localparam logic [KROW_W-1:0]    KTOP_RST   = 24'hFFFFFF;
  localparam logic [KROW_W-1:0]    KMID_RST   = 24'hFF08FF;
  localparam logic [KROW_W-1:0]    KBOT_RST   = 24'hFFFFFF;
  localparam logic [DIM_CFG_W-1:0] WIDTH_RST  = 13'd4096;
  localparam logic [DIM_CFG_W-1:0] HEIGHT_RST = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KROW_TOP = 3'd0,
    REG_KROW_MID = 3'd1,
    REG_KROW_BOT = 3'd2,
    REG_WIDTH    = 3'd3,
    REG_HEIGHT   = 3'd4
  } cfg_reg_t;

  // Control that travels with a window into the MAC pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } tap_ctl_t;

  // Left column sits in the high byte
  function automatic logic signed [COEF_W-1:0] coef_at(input logic [KROW_W-1:0] bits,
                                                       input logic [1:0] col);
    logic [COEF_W-1:0] b;
    b = bits[(KROW_W-1) - COEF_W*col -: COEF_W];
    return b;
  endfunction

endpackage

[rtl/core/ic3_ifs.sv]
interface ic3_pix_if;
  import ic3_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;
  logic               frame_start;
  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface ic3_res_if;
  import ic3_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] out_value;
  logic                    out_last;
  modport source (output valid, output out_value, output out_last, input ready);
  modport sink   (input valid, input out_value, input out_last, output ready);
endinterface

[rtl/core/ic3_ram.sv]
module ic3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/ic3_line.sv]
module ic3_line #(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    en,
  input  logic                                    acc,
  input  logic [PIXEL_BITS-1:0]                   pix,
  input  logic                                    frame_start,
  input  logic [ic3_pkg::DIM_CFG_W-1:0]           cfg_width,
  input  logic [ic3_pkg::DIM_CFG_W-1:0]           cfg_height,
  output logic [ic3_pkg::TAPS-1:0][PIXEL_BITS-1:0] win,
  output ic3_pkg::tap_ctl_t                       ctl
);
  import ic3_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int DIM_W = (COL_W + 1 > DIM_CFG_W) ? COL_W + 1 : DIM_CFG_W;

  logic [COL_W-1:0] col_r, col_nxt, col_cur;
  logic [ROW_W-1:0] row_r, row_nxt, row_cur;
  logic [DIM_W-1:0] w_use, h_use, w_raw, h_raw, col_inc, row_inc;
  logic             emit_cur, last_cur;

  logic                  s1_v_r, s1_emit_r, s1_last_r;
  logic [PIXEL_BITS-1:0] s1_pix_r;
  logic [COL_W-1:0]      s1_col_r;
  logic                  fwd_hit_r;
  logic [PIXEL_BITS-1:0] fwd_a_r, fwd_b_r;
  logic [PIXEL_BITS-1:0] a_rd, b_rd, mid_cur, top_cur;
  logic                  wr;

  logic [TAPS-1:0][PIXEL_BITS-1:0] win_r;
  tap_ctl_t                        ctl_r;

  // size clamp and position advance
  always_comb begin
    w_raw = DIM_W'(cfg_width);
    h_raw = DIM_W'(cfg_height);
    if (w_raw < DIM_W'(MIN_DIM)) begin
      w_use = DIM_W'(MIN_DIM);
    end else if (w_raw > DIM_W'(MAX_WIDTH)) begin
      w_use = DIM_W'(MAX_WIDTH);
    end else begin
      w_use = w_raw;
    end
    if (h_raw < DIM_W'(MIN_DIM)) begin
      h_use = DIM_W'(MIN_DIM);
    end else if (h_raw > DIM_W'(MAX_HEIGHT)) begin
      h_use = DIM_W'(MAX_HEIGHT);
    end else begin
      h_use = h_raw;
    end

    col_cur = frame_start ? '0 : col_r;
    row_cur = frame_start ? '0 : row_r;
    col_inc = DIM_W'(col_cur) + DIM_W'(1);
    row_inc = DIM_W'(row_cur) + DIM_W'(1);

    if (col_inc >= w_use) begin
      col_nxt = '0;
      row_nxt = (row_inc >= h_use) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_nxt = col_inc[COL_W-1:0];
      row_nxt = row_cur;
    end

    emit_cur = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
    last_cur = (DIM_W'(row_cur) == h_use - DIM_W'(1)) &&
               (DIM_W'(col_cur) == w_use - DIM_W'(1));
  end

  // item leaving the read stage writes its column back
  assign wr      = en && s1_v_r;
  assign mid_cur = fwd_hit_r ? fwd_a_r : a_rd;
  assign top_cur = fwd_hit_r ? fwd_b_r : b_rd;

  ic3_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_ram_a (
    .clk   (clk),
    .we    (wr),
    .waddr (s1_col_r),
    .wdata (s1_pix_r),
    .re    (acc),
    .raddr (col_cur),
    .rdata (a_rd)
  );

  ic3_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_ram_b (
    .clk   (clk),
    .we    (wr),
    .waddr (s1_col_r),
    .wdata (mid_cur),
    .re    (acc),
    .raddr (col_cur),
    .rdata (b_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      s1_v_r    <= 1'b0;
      ctl_r     <= '0;
      win_r     <= '0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (acc) begin
        col_r     <= col_nxt;
        row_r     <= row_nxt;
        // back-to-back hit on the column being written this edge
        fwd_hit_r <= wr && (s1_col_r == col_cur);
      end
      if (en) begin
        s1_v_r      <= acc;
        ctl_r.valid <= s1_v_r && s1_emit_r;
        ctl_r.last  <= s1_last_r;
      end
      if (wr) begin
        for (int r = 0; r < KDIM; r++) begin
          win_r[r*KDIM]     <= win_r[r*KDIM + 1];
          win_r[r*KDIM + 1] <= win_r[r*KDIM + 2];
        end
        win_r[2] <= top_cur;
        win_r[5] <= mid_cur;
        win_r[8] <= s1_pix_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r  <= pix;
      s1_col_r  <= col_cur;
      s1_emit_r <= emit_cur;
      s1_last_r <= last_cur;
      fwd_a_r   <= s1_pix_r;
      fwd_b_r   <= mid_cur;
    end
  end

  assign win = win_r;
  assign ctl = ctl_r;

endmodule

[rtl/core/ic3_mac.sv]
module ic3_mac #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    en,
  input  logic [ic3_pkg::TAPS-1:0][PIXEL_BITS-1:0] win,
  input  ic3_pkg::tap_ctl_t                       ctl,
  input  logic [ic3_pkg::KDIM-1:0][ic3_pkg::KROW_W-1:0] kernel,
  output logic                                    out_valid,
  output logic signed [ic3_pkg::OUT_W-1:0]        out_value,
  output logic                                    out_last
);
  import ic3_pkg::*;

  localparam int PROD_W = PIXEL_BITS + COEF_W + 1;
  localparam int RS_W   = PROD_W + 2;
  localparam int SUM_W  = PROD_W + 4;
  localparam int EXT_W  = SUM_W + OUT_W;

  logic signed [PROD_W-1:0] pix_ext [TAPS];
  logic signed [PROD_W-1:0] coef_ext [TAPS];
  logic signed [PROD_W-1:0] prod_nxt [TAPS];
  logic signed [PROD_W-1:0] prod_r [TAPS];
  logic signed [RS_W-1:0]   rs_nxt [KDIM];
  logic signed [RS_W-1:0]   rs_r [KDIM];
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [EXT_W-1:0]  sum_ext;

  logic                    p_v_r, p_last_r, rs_v_r, rs_last_r, out_valid_r, out_last_r;
  logic signed [OUT_W-1:0] out_value_r;

  always_comb begin
    for (int r = 0; r < KDIM; r++) begin
      for (int j = 0; j < KDIM; j++) begin
        pix_ext[r*KDIM + j]  = PROD_W'({1'b0, win[r*KDIM + j]});
        coef_ext[r*KDIM + j] = PROD_W'(coef_at(kernel[r], 2'(j)));
        prod_nxt[r*KDIM + j] = pix_ext[r*KDIM + j] * coef_ext[r*KDIM + j];
      end
    end
    for (int r = 0; r < KDIM; r++) begin
      rs_nxt[r] = RS_W'(prod_r[r*KDIM]) + RS_W'(prod_r[r*KDIM + 1]) +
                  RS_W'(prod_r[r*KDIM + 2]);
    end
    sum_nxt = SUM_W'(rs_r[0]) + SUM_W'(rs_r[1]) + SUM_W'(rs_r[2]);
    sum_ext = EXT_W'(sum_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r       <= 1'b0;
      rs_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      p_v_r       <= ctl.valid;
      rs_v_r      <= p_v_r;
      out_valid_r <= rs_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r      <= prod_nxt;
      p_last_r    <= ctl.last;
      rs_r        <= rs_nxt;
      rs_last_r   <= p_last_r;
      out_value_r <= sum_ext[OUT_W-1:0];
      out_last_r  <= rs_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule

[rtl/core/image_convolution_3x3.sv]
// Pipeline: the pixel that completes a window passes through line memory read, window
// shift, multiply, row sums and output register before the window's result is presented.
// Throughput: one pixel per cycle, set by the single read and write port of each line
// memory; a stalled result holds the whole pipeline and deasserts in_ch.ready.
// Reset: kernel and size registers to defaults, position and window to zero, pipeline
// empty; line memories are not cleared.
module image_convolution_3x3 #(
  parameter int MAX_WIDTH  = ic3_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = ic3_pkg::PIXEL_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ic3_pix_if.sink                        in_ch,
  ic3_res_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [ic3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ic3_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ic3_pkg::*;

  logic [KDIM-1:0][KROW_W-1:0] kernel_r;
  logic [DIM_CFG_W-1:0]        width_r, height_r;

  logic                            en, acc, out_valid;
  logic [TAPS-1:0][PIXEL_BITS-1:0] win;
  tap_ctl_t                        ctl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_r[0] <= KTOP_RST;
      kernel_r[1] <= KMID_RST;
      kernel_r[2] <= KBOT_RST;
      width_r     <= WIDTH_RST;
      height_r    <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_KROW_TOP: kernel_r[0] <= cfg_wdata;
        REG_KROW_MID: kernel_r[1] <= cfg_wdata;
        REG_KROW_BOT: kernel_r[2] <= cfg_wdata;
        REG_WIDTH:    width_r     <= cfg_wdata[DIM_CFG_W-1:0];
        REG_HEIGHT:   height_r    <= cfg_wdata[DIM_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign en          = !out_valid || out_ch.ready;
  assign acc         = in_ch.valid && en;
  assign in_ch.ready = en;

  ic3_line #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_line (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .acc         (acc),
    .pix         (PIXEL_BITS'(in_ch.pixel)),
    .frame_start (in_ch.frame_start),
    .cfg_width   (width_r),
    .cfg_height  (height_r),
    .win         (win),
    .ctl         (ctl)
  );

  ic3_mac #(.PIXEL_BITS(PIXEL_BITS)) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .win       (win),
    .ctl       (ctl),
    .kernel    (kernel_r),
    .out_valid (out_valid),
    .out_value (out_ch.out_value),
    .out_last  (out_ch.out_last)
  );

  assign out_ch.valid = out_valid;

endmodule

[tb/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ic3_pkg::*;

  localparam int MAX_W         = MAX_WIDTH_DEF;
  localparam int RANDOM_ITEMS  = 1550;
  localparam int BIG_AT        = 600;
  localparam int BIG_ITEMS     = 160;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 250;
  localparam int CYCLE_LIMIT   = 2_000_000;

  localparam logic [KROW_W-1:0] KERN_MAX = 24'h7F7F7F;
  localparam logic [KROW_W-1:0] KERN_MIN = 24'h808080;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic                    last;
  } conv_result_t;

  typedef enum int {PH_FRAMES, PH_NOISE, PH_SHRINK} phase_kind_t;

  // one directed step: either a register write or a pixel, optionally with a known result
  typedef struct packed {
    bit                      is_cfg;
    cfg_reg_t                reg_idx;
    logic [CFG_DATA_W-1:0]   data;
    logic                    fs;
    bit                      typed;
    logic signed [OUT_W-1:0] value;
    logic                    last;
  } directed_row_t;

  localparam directed_row_t DIRECTED [42] = '{
    // all coefficients +127, all pixels at full scale: largest sum
    '{1'b1, REG_KROW_TOP, KERN_MAX,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b1, REG_KROW_MID, KERN_MAX,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b1, REG_KROW_BOT, KERN_MAX,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b1, REG_WIDTH,    24'd3,       1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b1, REG_HEIGHT,   24'd3,       1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b0, REG_KROW_TOP, 24'hFFFF,    1'b1, 1'b0, 28'sd0, 1'b0},
    '{1'b0, REG_KROW_TOP, 24'hFFFF,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b0, REG_KROW_TOP, 24'hFFFF,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b0, REG_KROW_TOP, 24'hFFFF,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b0, REG_KROW_TOP, 24'hFFFF,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b0, REG_KROW_TOP, 24'hFFFF,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b0, REG_KROW_TOP, 24'hFFFF,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b0, REG_KROW_TOP, 24'hFFFF,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b0, REG_KROW_TOP, 24'hFFFF,    1'b0, 1'b1, 28'sd74906505, 1'b1},
    // all -128: smallest sum; next frame follows the wrap with no frame_start
    '{1'b1, REG_KROW_TOP, KERN_MIN,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b1, REG_KROW_MID, KERN_MIN,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b1, REG_KROW_BOT, KERN_MIN,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b0, REG_KROW_TOP, 24'hFFFF,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b0, REG_KROW_TOP, 24'hFFFF,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b0, REG_KROW_TOP, 24'hFFFF,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b0, REG_KROW_TOP, 24'hFFFF,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b0, REG_KROW_TOP, 24'hFFFF,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b0, REG_KROW_TOP, 24'hFFFF,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b0, REG_KROW_TOP, 24'hFFFF,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b0, REG_KROW_TOP, 24'hFFFF,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b0, REG_KROW_TOP, 24'hFFFF,    1'b0, 1'b1, -28'sd75496320, 1'b1},
    // default kernel, sizes below minimum clamp to 3x3, restart after two pixels
    '{1'b1, REG_KROW_TOP, KTOP_RST,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b1, REG_KROW_MID, KMID_RST,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b1, REG_KROW_BOT, KBOT_RST,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b1, REG_WIDTH,    24'd1,       1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b1, REG_HEIGHT,   24'd0,       1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b0, REG_KROW_TOP, 24'hFFFF,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b0, REG_KROW_TOP, 24'hFFFF,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b0, REG_KROW_TOP, 24'h0000,    1'b1, 1'b0, 28'sd0, 1'b0},
    '{1'b0, REG_KROW_TOP, 24'h0000,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b0, REG_KROW_TOP, 24'h0000,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b0, REG_KROW_TOP, 24'h0000,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b0, REG_KROW_TOP, 24'h0001,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b0, REG_KROW_TOP, 24'h0000,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b0, REG_KROW_TOP, 24'h0000,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b0, REG_KROW_TOP, 24'h0000,    1'b0, 1'b0, 28'sd0, 1'b0},
    '{1'b0, REG_KROW_TOP, 24'h0000,    1'b0, 1'b1, 28'sd8, 1'b1}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ic3_pix_if pix_if();
  ic3_res_if res_if();

  image_convolution_3x3 i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (pix_if.sink),
    .out_ch    (res_if.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [PIXEL_W-1:0]   line_prev  [MAX_W];
  logic [PIXEL_W-1:0]   line_prev2 [MAX_W];
  logic [PIXEL_W-1:0]   tap_win    [TAPS];
  int unsigned          col_pos, row_pos;
  logic [KROW_W-1:0]    coef_rows  [KDIM];
  logic [DIM_CFG_W-1:0] width_reg, height_reg;

  conv_result_t pending_results[$];
  conv_result_t seen_want;
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int unsigned  items_sent = 0;
  bit           sender_steady = 1'b0;
  bit           hold_request = 1'b0;
  bit           hold_done = 1'b0;

  function automatic int unsigned clamp_dim(input logic [DIM_CFG_W-1:0] v,
                                            input int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic bit convolve_pixel(input logic [PIXEL_W-1:0] pix, input logic fs,
                                        output conv_result_t res);
    int unsigned w, h, c, r;
    logic [PIXEL_W-1:0] above2, above1;
    logic signed [COEF_W-1:0] coef;
    int acc;
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    above2 = '0;
    above1 = '0;
    if (c < MAX_W) begin
      above2 = line_prev2[c];
      above1 = line_prev[c];
      line_prev2[c] = above1;
      line_prev[c] = pix;
    end
    for (int k = 0; k < KDIM; k++) begin
      tap_win[k*KDIM]   = tap_win[k*KDIM+1];
      tap_win[k*KDIM+1] = tap_win[k*KDIM+2];
    end
    tap_win[2] = above2;
    tap_win[5] = above1;
    tap_win[8] = pix;
    acc = 0;
    for (int i = 0; i < KDIM; i++) begin
      for (int j = 0; j < KDIM; j++) begin
        coef = COEF_W'(coef_rows[i] >> (2*COEF_W - COEF_W*j));
        acc += coef * int'(tap_win[i*KDIM + j]);
      end
    end
    res.value = acc[OUT_W-1:0];
    res.last  = (r == h - 1) && (c == w - 1);
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
    return (r >= 2) && (c >= 2);
  endfunction

  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PIXEL_W-1:0] rand_pixel();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return PIXEL_W'($urandom);
  endfunction

  function automatic logic [KROW_W-1:0] rand_kernel_row();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return KERN_MAX;
    if (pick == 1) return KERN_MIN;
    if (pick == 2) return '0;
    return KROW_W'($urandom);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("mismatch, cycle %0d: %s", cycle_count, what);
  endtask

  // entered and left at a falling edge; valid stays up after the item is taken
  task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input logic fs,
                            input bit typed = 1'b0,
                            input logic signed [OUT_W-1:0] typed_value = '0,
                            input logic typed_last = 1'b0);
    int unsigned gap;
    conv_result_t res;
    bit hit;
    gap = sender_steady ? 0 : idle_len();
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_if.valid       <= 1'b1;
    pix_if.pixel       <= pix;
    pix_if.frame_start <= fs;
    do @(posedge clk); while (pix_if.ready !== 1'b1);
    hit = convolve_pixel(pix, fs, res);
    if (typed) begin
      res.value = typed_value;
      res.last  = typed_last;
      pending_results.push_back(res);
    end else if (hit) begin
      pending_results.push_back(res);
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    pix_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_KROW_TOP: coef_rows[0] = data;
      REG_KROW_MID: coef_rows[1] = data;
      REG_KROW_BOT: coef_rows[2] = data;
      REG_WIDTH:    width_reg    = data[DIM_CFG_W-1:0];
      REG_HEIGHT:   height_reg   = data[DIM_CFG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic random_phase();
    phase_kind_t kind;
    int unsigned w_before, w, h, n, nf, pick, pause_at;
    bit lead_fs;
    drain_results();
    sender_steady = ($urandom_range(0, 3) == 0);
    w_before = clamp_dim(width_reg, MAX_W);
    if ($urandom_range(0, 3) != 0) write_reg(REG_KROW_TOP, rand_kernel_row());
    if ($urandom_range(0, 3) != 0) write_reg(REG_KROW_MID, rand_kernel_row());
    if ($urandom_range(0, 3) != 0) write_reg(REG_KROW_BOT, rand_kernel_row());
    if ($urandom_range(0, 2) != 0) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) write_reg(REG_WIDTH, CFG_DATA_W'($urandom_range(0, 2)));
      else if (pick < 4) write_reg(REG_WIDTH, CFG_DATA_W'($urandom_range(13, 40)));
      else write_reg(REG_WIDTH, CFG_DATA_W'($urandom_range(3, 12)));
    end
    if ($urandom_range(0, 2) != 0) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) write_reg(REG_HEIGHT, CFG_DATA_W'($urandom_range(0, 2)));
      else if (pick == 1) write_reg(REG_HEIGHT, CFG_DATA_W'($urandom_range(4096, 8191)));
      else write_reg(REG_HEIGHT, CFG_DATA_W'($urandom_range(3, 8)));
    end
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    // a wider row mid-frame would read line-store columns the last row never wrote
    lead_fs = (w > w_before) && (col_pos != 0 || row_pos != 0);
    pick = $urandom_range(0, 9);
    kind = (pick < 6) ? PH_FRAMES : (pick < 8) ? PH_NOISE : PH_SHRINK;
    case (kind)
      PH_FRAMES: begin
        nf = $urandom_range(1, 3);
        n = (w * h > 240) ? 240 : w * h;
        pause_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n - 1) : n;
        for (int f = 0; f < nf; f++) begin
          for (int p = 0; p < n; p++) begin
            send_pixel(rand_pixel(), (p == 0) && (f == 0 || $urandom_range(0, 1) == 1));
            if (f == 0 && p == pause_at) drain_results();
          end
        end
      end
      PH_NOISE: begin
        n = $urandom_range(20, 80);
        for (int p = 0; p < n; p++)
          send_pixel(rand_pixel(), (p == 0 && lead_fs) || $urandom_range(0, 15) == 0);
      end
      default: begin
        // shrink the frame part way through; the position must wrap at the new size
        n = (w * h > 150) ? 150 : w * h - 1;
        n = $urandom_range(1, n);
        for (int p = 0; p < n; p++) send_pixel(rand_pixel(), p == 0);
        drain_results();
        if (w > 3) write_reg(REG_WIDTH, CFG_DATA_W'($urandom_range(3, w - 1)));
        if (h > 3 && $urandom_range(0, 1) == 1)
          write_reg(REG_HEIGHT, CFG_DATA_W'($urandom_range(3, h - 1)));
        w = clamp_dim(width_reg, MAX_W);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        n = (2 * w * h > 300) ? 300 : 2 * w * h;
        for (int p = 0; p < n; p++) send_pixel(rand_pixel(), 1'b0);
      end
    endcase
  endtask

  initial begin : stimulus
    directed_row_t row;
    bit big_done;
    big_done = 1'b0;
    rst_n = 1'b0;
    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    pix_if.frame_start = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    for (int i = 0; i < MAX_W; i++) begin
      line_prev[i]  = '0;
      line_prev2[i] = '0;
    end
    for (int i = 0; i < TAPS; i++) tap_win[i] = '0;
    col_pos = 0;
    row_pos = 0;
    coef_rows[0] = KTOP_RST;
    coef_rows[1] = KMID_RST;
    coef_rows[2] = KBOT_RST;
    width_reg  = WIDTH_RST;
    height_reg = HEIGHT_RST;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      if (row.is_cfg) begin
        drain_results();
        write_reg(row.reg_idx, row.data);
      end else begin
        send_pixel(row.data[PIXEL_W-1:0], row.fs, row.typed, row.value, row.last);
      end
    end

    while (items_sent < RANDOM_ITEMS) begin
      if (!big_done && items_sent >= BIG_AT) begin
        // small frames offered back to back while the receiver holds off
        drain_results();
        write_reg(REG_WIDTH, 24'd4);
        write_reg(REG_HEIGHT, 24'd8);
        write_reg(REG_KROW_MID, rand_kernel_row());
        sender_steady = 1'b1;
        hold_request = 1'b1;
        for (int p = 0; p < BIG_ITEMS; p++) send_pixel(rand_pixel(), p == 0);
        big_done = 1'b1;
      end else begin
        random_phase();
      end
    end

    drain_results();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned run, gap;
    res_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      res_if.ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
      for (int k = 0; k < run && !(hold_request && !hold_done); k++) @(negedge clk);
      if (hold_request && !hold_done) begin
        // long back-pressure so the pipeline fills and stalls the pixel input
        hold_done = 1'b1;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        gap = idle_len();
        if (gap > 0) begin
          res_if.ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d with none expected", res_if.out_value));
      end else begin
        seen_want = pending_results.pop_front();
        if (res_if.out_value !== seen_want.value)
          report_mismatch($sformatf("out_value %0d, want %0d",
                                    res_if.out_value, seen_want.value));
        if (res_if.out_last !== seen_want.last)
          report_mismatch($sformatf("out_last %0b, want %0b",
                                    res_if.out_last, seen_want.last));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
